@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the digest blocklist table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hbt_pkg.sv @@
// Types and constants of the digest blocklist table.
package hbt_pkg;

  localparam int KEY_W           = 256;
  localparam int WORD_W          = 64;
  localparam int SEV_W           = 7;
  localparam int DEFAULT_ENTRIES = 64;

  localparam logic [SEV_W-1:0] SEV_MAX = 7'd100;

  // Command codes
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [WORD_W-1:0] key_word_0;
    logic [WORD_W-1:0] key_word_1;
    logic [WORD_W-1:0] key_word_2;
    logic [WORD_W-1:0] key_word_3;
    logic [SEV_W-1:0]  severity_in;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [SEV_W-1:0] found_severity;
    logic             status;
  } out_item_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             active;
    logic             hit;
    logic [SEV_W-1:0] found_sev;
    logic             free_found;
  } tok_t;

  // Controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic is_insert;
    logic clear;
    logic alloc_en;
  } ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

@@ rtl/hbt_cell.sv @@
// One table slot: stored key and severity, compare against the search token.
module hbt_cell #(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  hbt_pkg::ctrl_t           ctrl,
  input  logic [IDX_W-1:0]         alloc_idx,
  input  logic [hbt_pkg::KEY_W-1:0] key_i,
  input  logic [hbt_pkg::SEV_W-1:0] sev_i,
  input  hbt_pkg::tok_t            tok_i,
  input  logic [IDX_W-1:0]         free_idx_i,
  output hbt_pkg::tok_t            tok_o,
  output logic [IDX_W-1:0]         free_idx_o
);
  import hbt_pkg::*;

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [SEV_W-1:0] sev_r, sev_nxt;
  tok_t             tok_r, tok_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             match;
  logic             first_free;
  logic             alloc_here;

  assign match      = tok_i.active & valid_r & (key_r == key_i);
  assign first_free = tok_i.active & ~valid_r & ~tok_i.free_found;
  assign alloc_here = ctrl.alloc_en & (alloc_idx == IDX_W'(CELL_IDX));

  // Merge this slot into the passing token
  always_comb begin
    tok_nxt.active     = tok_i.active;
    tok_nxt.hit        = tok_i.hit | match;
    tok_nxt.found_sev  = match ? sev_r : tok_i.found_sev;
    tok_nxt.free_found = tok_i.free_found | first_free;
    free_idx_nxt       = first_free ? IDX_W'(CELL_IDX) : free_idx_i;
  end

  // Update slot contents: clear, allocate, or overwrite severity on an insert hit
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    sev_nxt   = sev_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (alloc_here) begin
      valid_nxt = 1'b1;
      key_nxt   = key_i;
      sev_nxt   = sev_i;
    end else if (match && ctrl.is_insert) begin
      sev_nxt = sev_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    sev_r      <= sev_nxt;
    free_idx_r <= free_idx_nxt;
  end

  assign tok_o      = tok_r;
  assign free_idx_o = free_idx_r;

endmodule

@@ rtl/hash_blocklist_table_top.sv @@
// Top level of the digest blocklist table: sequencer and the chain of slot cells.
//
// Exact-match table of 256-bit digest keys with a 7-bit severity each. Assert start
// with a command on in_item while busy is low; busy rises on the next cycle and one
// result appears on out_item for exactly one cycle with out_valid high. There is no
// backpressure: capture the result in that cycle. A lookup or insert sends a search
// token down the chain of ENTRIES cells, one cell per cycle, and the next command is
// accepted only after the token leaves the tail and the result is given. A clear or an
// unused command code skips the chain. Inserted severities saturate at 100. No clearing
// pass is needed after reset: the table comes up empty.
module hash_blocklist_table_top #(
  parameter int ENTRIES = hbt_pkg::DEFAULT_ENTRIES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  hbt_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output hbt_pkg::out_item_t out_item
);
  import hbt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  state_t           state_r, state_nxt;
  logic             inj_r;
  logic [1:0]       cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [SEV_W-1:0] sev_r;
  logic [SEV_W-1:0] sev_sat;
  logic             hit_r;
  logic [SEV_W-1:0] found_r;
  logic             status_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             accept;
  ctrl_t            ctrl;

  tok_t             tok   [ENTRIES+1];
  logic [IDX_W-1:0] fidx  [ENTRIES+1];

  assign sev_sat = (in_item.severity_in > SEV_MAX) ? SEV_MAX : in_item.severity_in;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_item.command == CMD_LOOKUP || in_item.command == CMD_INSERT) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (tok[ENTRIES].active) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy          = 1'b1;
    out_valid     = 1'b0;
    accept        = 1'b0;
    ctrl.is_insert = (cmd_r == CMD_INSERT);
    ctrl.clear     = 1'b0;
    ctrl.alloc_en  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      ST_SCAN: begin
      end
      ST_FINISH: begin
        out_valid     = 1'b1;
        ctrl.clear    = (cmd_r == CMD_CLEAR);
        ctrl.alloc_en = (cmd_r == CMD_INSERT) & ~hit_r & free_found_r;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      inj_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      inj_r   <= accept &
                 (in_item.command == CMD_LOOKUP || in_item.command == CMD_INSERT);
    end
  end

  // Latch the transaction and collect the result from the chain tail
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r        <= in_item.command;
      key_r        <= {in_item.key_word_0, in_item.key_word_1,
                       in_item.key_word_2, in_item.key_word_3};
      sev_r        <= sev_sat;
      hit_r        <= 1'b0;
      found_r      <= '0;
      status_r     <= 1'b0;
      free_found_r <= 1'b0;
    end else if (state_r == ST_SCAN && tok[ENTRIES].active) begin
      hit_r        <= tok[ENTRIES].hit;
      found_r      <= tok[ENTRIES].found_sev;
      status_r     <= (cmd_r == CMD_INSERT) & ~tok[ENTRIES].hit &
                      ~tok[ENTRIES].free_found;
      free_found_r <= tok[ENTRIES].free_found;
      free_idx_r   <= fidx[ENTRIES];
    end
  end

  // Feed a fresh token into the head of the chain
  assign tok[0]  = '{active: inj_r, hit: 1'b0, found_sev: '0, free_found: 1'b0};
  assign fidx[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    hbt_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .alloc_idx  (free_idx_r),
      .key_i      (key_r),
      .sev_i      (sev_r),
      .tok_i      (tok[i]),
      .free_idx_i (fidx[i]),
      .tok_o      (tok[i+1]),
      .free_idx_o (fidx[i+1])
    );
  end

  assign out_item.hit            = hit_r;
  assign out_item.found_severity = found_r;
  assign out_item.status         = status_r;

  `include "assert_macros.svh"

  `HBT_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_valid, busy, "result strobe while idle")
  `HBT_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept did not raise busy")
  `HBT_ASSERT_IMP(a_tail_in_scan, clk, rst_n, tok[ENTRIES].active, state_r == ST_SCAN, "stray token")
  `HBT_ASSERT_IMP(a_alloc_miss, clk, rst_n, ctrl.alloc_en, !hit_r && !status_r, "bad allocation")

endmodule
